// ===== hw/rtl/ewaq_pkg.sv =====
// ewaq_pkg: shared widths, constants, beat types and saturating helpers
// for the streaming quantile estimator; no dependencies
`default_nettype none

package ewaq_pkg;

    // fixed-point layout of the state and of the sample
    localparam int FRAC_BITS = 16;
    localparam int SAMPLE_W  = 31;
    localparam int X_W       = SAMPLE_W + FRAC_BITS;
    localparam int STATE_W   = 64;
    localparam int SUM_W     = STATE_W + 2;
    localparam int EST_W     = 48;
    localparam int DIST_BITS = 46;

    // settings are Q0.16, factors reach one so they carry one extra bit
    localparam int SET_W     = 16;
    localparam int FACT_W    = SET_W + 1;
    localparam int PROD_W    = STATE_W + FACT_W;
    localparam int MUL_STEPS = FACT_W;
    localparam int DIV_STEPS = SET_W;
    localparam int CNT_W     = $clog2(MUL_STEPS + 1);

    localparam logic [FACT_W-1:0] ONE_Q  = {1'b1, {SET_W{1'b0}}};
    localparam logic [FACT_W-1:0] HALF_Q = {2'b01, {(SET_W-1){1'b0}}};

    localparam logic signed [STATE_W-1:0] ONE_X =
        {{(STATE_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [STATE_W-1:0] STATE_LIM = {2'b01, {(STATE_W-2){1'b0}}};
    localparam logic signed [STATE_W-1:0] NEG_LIM   = {2'b11, {(STATE_W-2){1'b0}}};
    localparam logic signed [STATE_W-1:0] EST_MAX =
        {{(STATE_W-EST_W+1){1'b0}}, {(EST_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0] EST_MIN =
        {{(STATE_W-EST_W+1){1'b1}}, {(EST_W-1){1'b0}}};

    // register map of the write port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTILE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TRACK    = CFG_IDX_W'(2);

    localparam logic [SET_W-1:0] QUANTILE_RST = SET_W'(58982);
    localparam logic [SET_W-1:0] STEP_RST     = SET_W'(655);
    localparam logic [SET_W-1:0] TRACK_RST    = SET_W'(66);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                first_of_stream;
        logic                last_of_stream;
    } in_beat_t;

    typedef struct packed {
        logic signed [EST_W-1:0] estimate;
        logic                    is_final;
        logic                    div_fault;
    } out_beat_t;

    typedef struct packed {
        logic [SET_W-1:0] quantile_level;
        logic [SET_W-1:0] step_size;
        logic [SET_W-1:0] tracking_rate;
    } cfg_t;

    // command to the serial multiply / divide unit
    typedef struct packed {
        logic               start;
        logic               is_div;
        logic [STATE_W-1:0] opa;
        logic [STATE_W-1:0] opb;
    } md_cmd_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] prod;
        logic [SET_W-1:0]  quo;
    } md_rsp_t;

    // a plus b clamped to the state range
    function automatic logic signed [STATE_W-1:0] sat_add(
        input logic signed [STATE_W-1:0] a,
        input logic signed [STATE_W-1:0] b
    );
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s > SUM_W'(STATE_LIM)) return STATE_LIM;
        if (s < SUM_W'(NEG_LIM)) return NEG_LIM;
        return $signed(s[STATE_W-1:0]);
    endfunction

    // clamp of the state to the output width
    function automatic logic signed [EST_W-1:0] sat_est(input logic signed [STATE_W-1:0] v);
        logic signed [STATE_W-1:0] c;
        c = v;
        if (v > EST_MAX) c = EST_MAX;
        if (v < EST_MIN) c = EST_MIN;
        return $signed(c[EST_W-1:0]);
    endfunction

    function automatic logic [STATE_W-1:0] mag(input logic signed [STATE_W-1:0] v);
        logic [STATE_W-1:0] u;
        u = $unsigned(v);
        return v[STATE_W-1] ? (~u + 1'b1) : u;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ewaq_muldiv.sv =====
// ewaq_muldiv: shared serial unit, shift-add multiply one factor bit per cycle
// and restoring divide one quotient bit per cycle; uses ewaq_pkg
`default_nettype none

module ewaq_muldiv import ewaq_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire md_cmd_t cmd,
    output md_rsp_t      rsp
);

    logic [STATE_W-1:0] acc_reg, acc_next;
    logic [FACT_W-1:0]  sh_reg, sh_next;
    logic [STATE_W-1:0] m_reg, m_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               div_reg, div_next;
    logic               done_reg, done_next;

    logic [STATE_W:0] sum;
    logic [STATE_W:0] rem_sh;
    logic [STATE_W:0] rem_sub;
    logic             ge;

    // one multiply add and one divide trial per cycle
    always_comb begin
        sum     = {1'b0, acc_reg} + (sh_reg[0] ? {1'b0, m_reg} : '0);
        rem_sh  = {acc_reg, 1'b0};
        ge      = rem_sh >= {1'b0, m_reg};
        rem_sub = rem_sh - {1'b0, m_reg};
    end

    // step sequencing
    always_comb begin
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        m_next    = m_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            busy_next = 1'b1;
            div_next  = cmd.is_div;
            if (cmd.is_div) begin
                acc_next = cmd.opa;
                m_next   = cmd.opb;
                sh_next  = '0;
                cnt_next = CNT_W'(DIV_STEPS);
            end else begin
                acc_next = '0;
                m_next   = cmd.opa;
                sh_next  = cmd.opb[FACT_W-1:0];
                cnt_next = CNT_W'(MUL_STEPS);
            end
        end else if (busy_reg) begin
            if (div_reg) begin
                acc_next = ge ? rem_sub[STATE_W-1:0] : rem_sh[STATE_W-1:0];
                sh_next  = {sh_reg[FACT_W-2:0], ge};
            end else begin
                acc_next = sum[STATE_W:1];
                sh_next  = {sum[0], sh_reg[FACT_W-1:1]};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            div_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            div_reg  <= div_next;
        end
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        m_reg   <= m_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = {acc_reg, sh_reg};
    assign rsp.quo  = sh_reg[SET_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/ewaq_seq.sv =====
// ewaq_seq: per-item sequencer, estimate and marker state, weight and step
// datapath; uses ewaq_pkg and ewaq_muldiv
`default_nettype none

module ewaq_seq import ewaq_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire cfg_t     cfg,
    input  wire in_beat_t in_data,
    input  wire logic     in_valid,
    output logic          in_ready,
    output out_beat_t     res_data,
    output logic          res_valid,
    input  wire logic     res_ready
);

    typedef enum logic [23:0] {
        ST_IDLE      = 24'h00_0001,
        ST_INIT      = 24'h00_0002,
        ST_DIFF      = 24'h00_0004,
        ST_ABS       = 24'h00_0008,
        ST_NORM      = 24'h00_0010,
        ST_NUM_GO    = 24'h00_0020,
        ST_NUM_WAIT  = 24'h00_0040,
        ST_DEN_GO    = 24'h00_0080,
        ST_DEN_WAIT  = 24'h00_0100,
        ST_WABS      = 24'h00_0200,
        ST_WCHK      = 24'h00_0400,
        ST_DIV_GO    = 24'h00_0800,
        ST_DIV_WAIT  = 24'h00_1000,
        ST_B_GO      = 24'h00_2000,
        ST_B_WAIT    = 24'h00_4000,
        ST_STEP_GO   = 24'h00_8000,
        ST_STEP_WAIT = 24'h01_0000,
        ST_UPDQ      = 24'h02_0000,
        ST_DELTA     = 24'h04_0000,
        ST_TRK_GO    = 24'h08_0000,
        ST_TRK_WAIT  = 24'h10_0000,
        ST_MRK1      = 24'h20_0000,
        ST_MRK2      = 24'h40_0000,
        ST_DONE      = 24'h80_0000
    } state_t;

    state_t state_reg, state_next;

    logic primed_reg;
    logic last_reg;
    logic fault_reg;
    logic above_reg;
    logic [X_W-1:0] x_reg;

    logic signed [STATE_W-1:0] est_reg, upr_reg, lwr_reg;
    logic signed [STATE_W-1:0] dp_reg, dn_reg, dx_reg;
    logic [STATE_W-1:0]        mp_reg, mn_reg;
    logic                      sp_reg, sn_reg;
    logic signed [STATE_W-1:0] num_reg, den_reg;
    logic [STATE_W-1:0]        an_reg, ad_reg;
    logic [FACT_W-1:0]         a_reg;
    logic [SET_W-1:0]          b_reg;
    logic signed [STATE_W-1:0] step_reg, q1_reg, tx_reg, delta_reg, trk_reg;

    md_cmd_t md_cmd;
    md_rsp_t md_rsp;

    logic signed [STATE_W-1:0] x_s;
    logic signed [STATE_W-1:0] prod_lo;
    logic signed [STATE_W-1:0] frac_s;
    logic                      wide;

    ewaq_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (md_cmd),
        .rsp     (md_rsp)
    );

    assign x_s     = $signed({{(STATE_W-X_W){1'b0}}, x_reg});
    assign prod_lo = $signed(md_rsp.prod[STATE_W-1:0]);
    // truncated product magnitude d*f/2^16, below 2^63 so positive as signed
    assign frac_s  = $signed(md_rsp.prod[STATE_W+SET_W-1:SET_W]);
    assign wide    = (|mp_reg[STATE_W-1:DIST_BITS]) || (|mn_reg[STATE_W-1:DIST_BITS]);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = (in_data.first_of_stream || !primed_reg) ? ST_INIT : ST_DIFF;
                end
            end
            ST_INIT:     state_next = ST_DONE;
            ST_DIFF:     state_next = ST_ABS;
            ST_ABS:      state_next = ST_NORM;
            ST_NORM:     state_next = wide ? ST_NORM : ST_NUM_GO;
            ST_NUM_GO:   state_next = ST_NUM_WAIT;
            ST_NUM_WAIT: state_next = md_rsp.done ? ST_DEN_GO : ST_NUM_WAIT;
            ST_DEN_GO:   state_next = ST_DEN_WAIT;
            ST_DEN_WAIT: state_next = md_rsp.done ? ST_WABS : ST_DEN_WAIT;
            ST_WABS:     state_next = ST_WCHK;
            ST_WCHK: begin
                if (den_reg == '0) begin
                    state_next = ST_B_GO;
                end else if (num_reg == '0 || (num_reg[STATE_W-1] != den_reg[STATE_W-1])) begin
                    state_next = ST_B_GO;
                end else if (an_reg >= ad_reg) begin
                    state_next = ST_B_GO;
                end else begin
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:    state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  state_next = md_rsp.done ? ST_B_GO : ST_DIV_WAIT;
            ST_B_GO:      state_next = ST_B_WAIT;
            ST_B_WAIT:    state_next = md_rsp.done ? ST_STEP_GO : ST_B_WAIT;
            ST_STEP_GO:   state_next = ST_STEP_WAIT;
            ST_STEP_WAIT: state_next = md_rsp.done ? ST_UPDQ : ST_STEP_WAIT;
            ST_UPDQ:      state_next = ST_DELTA;
            ST_DELTA:     state_next = ST_TRK_GO;
            ST_TRK_GO:    state_next = ST_TRK_WAIT;
            ST_TRK_WAIT:  state_next = md_rsp.done ? ST_MRK1 : ST_TRK_WAIT;
            ST_MRK1:      state_next = ST_MRK2;
            ST_MRK2:      state_next = ST_DONE;
            ST_DONE:      state_next = res_ready ? ST_IDLE : ST_DONE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // operands for the shared unit
    always_comb begin
        md_cmd = '0;
        case (state_reg)
            ST_NUM_GO: begin
                md_cmd.start = 1'b1;
                md_cmd.opa   = mn_reg;
                md_cmd.opb   = STATE_W'(cfg.quantile_level);
            end
            ST_DEN_GO: begin
                md_cmd.start = 1'b1;
                md_cmd.opa   = mp_reg;
                md_cmd.opb   = STATE_W'(ONE_Q - FACT_W'(cfg.quantile_level));
            end
            ST_DIV_GO: begin
                md_cmd.start  = 1'b1;
                md_cmd.is_div = 1'b1;
                md_cmd.opa    = an_reg;
                md_cmd.opb    = ad_reg;
            end
            ST_B_GO: begin
                md_cmd.start = 1'b1;
                md_cmd.opa   = STATE_W'(cfg.step_size);
                md_cmd.opb   = STATE_W'(above_reg ? a_reg : ONE_Q - a_reg);
            end
            ST_STEP_GO: begin
                md_cmd.start = 1'b1;
                md_cmd.opa   = mag(dx_reg);
                md_cmd.opb   = STATE_W'(b_reg);
            end
            ST_TRK_GO: begin
                md_cmd.start = 1'b1;
                md_cmd.opa   = mag(tx_reg);
                md_cmd.opb   = STATE_W'(cfg.tracking_rate);
            end
            default: md_cmd = '0;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            primed_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_INIT) begin
                primed_reg <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    x_reg     <= {in_data.sample, {FRAC_BITS{1'b0}}};
                    last_reg  <= in_data.last_of_stream;
                    fault_reg <= 1'b0;
                end
            end
            // start of stream
            ST_INIT: begin
                est_reg <= x_s;
                upr_reg <= x_s + ONE_X;
                lwr_reg <= x_s - ONE_X;
            end
            // marker distances and distance to the sample
            ST_DIFF: begin
                dp_reg    <= upr_reg - est_reg;
                dn_reg    <= est_reg - lwr_reg;
                dx_reg    <= x_s - est_reg;
                above_reg <= x_s > est_reg;
            end
            ST_ABS: begin
                mp_reg <= mag(dp_reg);
                mn_reg <= mag(dn_reg);
                sp_reg <= dp_reg[STATE_W-1];
                sn_reg <= dn_reg[STATE_W-1];
            end
            // scale both distances down one bit a cycle
            ST_NORM: begin
                if (wide) begin
                    mp_reg <= mp_reg >> 1;
                    mn_reg <= mn_reg >> 1;
                end
            end
            ST_NUM_WAIT: begin
                if (md_rsp.done) begin
                    num_reg <= sn_reg ? -prod_lo : prod_lo;
                end
            end
            ST_DEN_WAIT: begin
                if (md_rsp.done) begin
                    den_reg <= sp_reg ? num_reg - prod_lo : num_reg + prod_lo;
                end
            end
            ST_WABS: begin
                an_reg <= mag(num_reg);
                ad_reg <= mag(den_reg);
            end
            // weight special cases
            ST_WCHK: begin
                if (den_reg == '0) begin
                    fault_reg <= 1'b1;
                    a_reg     <= HALF_Q;
                end else if (num_reg == '0 || (num_reg[STATE_W-1] != den_reg[STATE_W-1])) begin
                    a_reg <= '0;
                end else if (an_reg >= ad_reg) begin
                    a_reg <= ONE_Q;
                end
            end
            ST_DIV_WAIT: begin
                if (md_rsp.done) begin
                    a_reg <= {1'b0, md_rsp.quo};
                end
            end
            ST_B_WAIT: begin
                if (md_rsp.done) begin
                    b_reg <= md_rsp.prod[2*SET_W-1:SET_W];
                end
            end
            ST_STEP_WAIT: begin
                if (md_rsp.done) begin
                    step_reg <= dx_reg[STATE_W-1] ? -frac_s : frac_s;
                end
            end
            ST_UPDQ: begin
                q1_reg <= sat_add(est_reg, step_reg);
                tx_reg <= x_s - (above_reg ? upr_reg : lwr_reg);
            end
            ST_DELTA: begin
                delta_reg <= q1_reg - est_reg;
            end
            ST_TRK_WAIT: begin
                if (md_rsp.done) begin
                    trk_reg <= tx_reg[STATE_W-1] ? -frac_s : frac_s;
                end
            end
            // both markers follow the estimate
            ST_MRK1: begin
                est_reg <= q1_reg;
                upr_reg <= sat_add(upr_reg, delta_reg);
                lwr_reg <= sat_add(lwr_reg, delta_reg);
            end
            // the marker on the sample's side tracks the sample
            ST_MRK2: begin
                if (above_reg) begin
                    upr_reg <= sat_add(upr_reg, trk_reg);
                end else begin
                    lwr_reg <= sat_add(lwr_reg, trk_reg);
                end
            end
            default: begin
            end
        endcase
    end

    assign in_ready           = (state_reg == ST_IDLE);
    assign res_valid          = (state_reg == ST_DONE);
    assign res_data.estimate  = sat_est(est_reg);
    assign res_data.is_final  = last_reg;
    assign res_data.div_fault = fault_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ewa_streaming_quantile_estimator_core.sv =====
// ewa_streaming_quantile_estimator_core: top level with settings registers,
// input handshake and result register; uses ewaq_pkg and ewaq_seq
//
// Usage:
//   s_valid/s_ready/s_data carry one sample beat; m_valid/m_ready/m_data carry
//   one result beat per sample (estimate, is_final, div_fault). cfg_wr_en,
//   cfg_index and cfg_wdata write quantile_level, step_size and tracking_rate
//   (index 0, 1, 2; others drop); the user writes only while the block is idle, unchecked.
// Sequencing:
//   a first-of-stream beat goes from acceptance through an init state to its
//   result; an update beat runs five multiplies and one divide on the shared
//   serial unit, each with a launch and a pickup state, normalize shifts when
//   marker distances are wide, and single states of adds, checks and handoff.
//   The divide is skipped when the weight is settled by a special case.
//   One sample is in work at a time.
// Reset (aresetn low, synchronous) restores the default settings, drops any
//   result and clears the stream, so the next sample starts a new stream.
// A stalled receiver leaves the result in the output register; the next
//   sample is still accepted and worked on, and waits only at its result.
`default_nettype none

module ewa_streaming_quantile_estimator_core import ewaq_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_beat_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_beat_t                 m_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SET_W-1:0]     cfg_wdata
);

    cfg_t      cfg_reg;
    logic      m_valid_reg;
    out_beat_t m_data_reg;
    out_beat_t res_data;
    logic      res_valid;
    logic      res_ready;

    // settings registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quantile_level <= QUANTILE_RST;
            cfg_reg.step_size      <= STEP_RST;
            cfg_reg.tracking_rate  <= TRACK_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_QUANTILE: cfg_reg.quantile_level <= cfg_wdata;
                REG_STEP:     cfg_reg.step_size      <= cfg_wdata;
                REG_TRACK:    cfg_reg.tracking_rate  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    ewaq_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_data   (s_data),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .res_data  (res_data),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    // result register between the sequencer and the receiver
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input beat accepted while a sample is in work");

    a_res_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_ready)
        else $error("result offered while input side is open");

    a_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> m_valid)
        else $error("result handed off but output beat not shown");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> (s_ready && !m_valid))
        else $error("reset did not leave the block idle and empty");

endmodule

`default_nettype wire
